/* design/rbwa_pkg.sv */
package rbwa_pkg;

    localparam int DEPTH_DEF  = 128;
    localparam int WINDOW_DEF = 60;

    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int SAMPLE_W = 16;

    localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_AVG  = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_SHORT = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_SUM,
        ST_ABS,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } rbwa_state_t;

endpackage

/* design/ring_buffer_window_average.sv */
// Ring buffer of signed Q8.8 samples with a window average over the oldest entries.
// Input words arrive on s_tvalid/s_tready: s_tuser selects push, pop or average
// query, and s_tdata carries the sample for a push. Each input word produces exactly
// one result word on m_tvalid/m_tready, with the value in m_tdata and the status in
// m_tuser. A push, an error answer or an unused function goes from acceptance straight
// to the DONE state and from there into the output register, and a pop passes through
// the POP state first. A successful average query walks the SUM state, which streams
// the oldest WINDOW entries out of the sample memory, one read per cycle; ABS then takes
// the magnitude of the sum, DIV multiplies it by the reciprocal of WINDOW and FIN
// restores the sign. Only one word is processed at a time, and s_tready returns in the
// cycle after the result is loaded. The next word is accepted while the previous result
// still waits in the output register. A stalled receiver holds the output register, and
// once the next result is finished the block stops accepting input. Reset clears the
// pointers, marks the buffer empty and drops any pending result. The sample memory is
// not cleared, so entries read before they are written hold unknown data.
module ring_buffer_window_average
    import rbwa_pkg::*;
#(
    parameter int DEPTH  = DEPTH_DEF,
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic signed [SAMPLE_W-1:0] s_tdata,   // [15:0] sample
    input  logic        [FUNC_W-1:0]   s_tuser,   // [1:0] func
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic signed [SAMPLE_W-1:0] m_tdata,   // [15:0] value
    output logic        [STATUS_W-1:0] m_tuser    // [1:0] status
);

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int WIN_W  = $clog2(WINDOW + 1);
    localparam int CMP_W  = ((PTR_W > WIN_W) ? PTR_W : WIN_W) + 1;
    localparam int SUM_W  = SAMPLE_W + WIN_W;
    localparam int MAG_W  = SUM_W - 1;
    localparam int RCP_SH = MAG_W + $clog2(WINDOW);
    localparam int RCP_W  = MAG_W + 1;
    localparam int PROD_W = MAG_W + RCP_W;
    localparam logic [63:0] RCP_FULL =
        ((64'd1 << RCP_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [RCP_W-1:0] RECIP = RCP_FULL[RCP_W-1:0];

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    logic [SAMPLE_W-1:0] mem [DEPTH];

    rbwa_state_t                state_reg, state_next;
    logic        [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic        [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic        [PTR_W-1:0]    walk_ptr_reg, walk_ptr_next;
    logic                       empty_reg, empty_next;
    logic        [WIN_W-1:0]    cnt_reg, cnt_next;
    logic signed [SUM_W-1:0]    acc_reg, acc_next;
    logic        [MAG_W-1:0]    mag_reg, mag_next;
    logic        [PROD_W-1:0]   prod_reg, prod_next;
    logic                       neg_reg, neg_next;
    logic        [SAMPLE_W-1:0] res_value_reg, res_value_next;
    logic        [STATUS_W-1:0] res_status_reg, res_status_next;
    logic        [SAMPLE_W-1:0] rd_data_reg;
    logic                       m_valid_reg;
    logic        [SAMPLE_W-1:0] m_value_reg;
    logic        [STATUS_W-1:0] m_status_reg;

    logic                       in_fire;
    logic                       out_load;
    logic                       mem_we;
    logic                       mem_re;
    logic        [PTR_W-1:0]    mem_raddr;
    logic        [CMP_W-1:0]    fill_count;
    logic                       is_short;
    logic                       sum_last;
    logic        [SAMPLE_W-1:0] quot;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    assign fill_count = (wr_ptr_reg >= rd_ptr_reg)
                      ? CMP_W'(wr_ptr_reg) - CMP_W'(rd_ptr_reg)
                      : CMP_W'(wr_ptr_reg) + CMP_W'(DEPTH) - CMP_W'(rd_ptr_reg);
    assign is_short = fill_count < CMP_W'(WINDOW);
    assign sum_last = (cnt_reg == WIN_W'(WINDOW - 1));

    assign quot = prod_reg[RCP_SH +: SAMPLE_W];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    unique case (s_tuser)
                        FUNC_POP: state_next = empty_reg ? ST_DONE : ST_POP;
                        FUNC_AVG: state_next = (empty_reg || is_short) ? ST_DONE : ST_SUM;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_POP:  state_next = ST_DONE;
            ST_SUM:  state_next = sum_last ? ST_ABS : ST_SUM;
            ST_ABS:  state_next = ST_DIV;
            ST_DIV:  state_next = ST_FIN;
            ST_FIN:  state_next = ST_DONE;
            ST_DONE: state_next = out_load ? ST_IDLE : ST_DONE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        wr_ptr_next     = wr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        walk_ptr_next   = walk_ptr_reg;
        empty_next      = empty_reg;
        cnt_next        = cnt_reg;
        acc_next        = acc_reg;
        mag_next        = mag_reg;
        prod_next       = prod_reg;
        neg_next        = neg_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_raddr       = rd_ptr_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    res_value_next  = '0;
                    res_status_next = STAT_OK;
                    unique case (s_tuser)
                        FUNC_PUSH: begin
                            mem_we      = 1'b1;
                            wr_ptr_next = wrap_inc(wr_ptr_reg);
                            empty_next  = 1'b0;
                            if (wrap_inc(wr_ptr_reg) == rd_ptr_reg) begin
                                rd_ptr_next = wrap_inc(rd_ptr_reg);
                            end
                        end
                        FUNC_POP: begin
                            if (empty_reg) begin
                                res_status_next = STAT_EMPTY;
                            end else begin
                                mem_re      = 1'b1;
                                rd_ptr_next = wrap_inc(rd_ptr_reg);
                                empty_next  = (wrap_inc(rd_ptr_reg) == wr_ptr_reg);
                            end
                        end
                        FUNC_AVG: begin
                            if (empty_reg) begin
                                res_status_next = STAT_EMPTY;
                            end else if (is_short) begin
                                res_status_next = STAT_SHORT;
                            end else begin
                                mem_re        = 1'b1;
                                walk_ptr_next = wrap_inc(rd_ptr_reg);
                                cnt_next      = '0;
                                acc_next      = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_POP: begin
                res_value_next = rd_data_reg;
            end
            ST_SUM: begin
                acc_next      = acc_reg
                              + {{(SUM_W - SAMPLE_W){rd_data_reg[SAMPLE_W-1]}}, rd_data_reg};
                cnt_next      = cnt_reg + WIN_W'(1);
                mem_re        = 1'b1;
                mem_raddr     = walk_ptr_reg;
                walk_ptr_next = wrap_inc(walk_ptr_reg);
            end
            ST_ABS: begin
                neg_next = acc_reg[SUM_W-1];
                mag_next = acc_reg[SUM_W-1] ? MAG_W'(-acc_reg) : MAG_W'(acc_reg);
            end
            ST_DIV: begin
                prod_next = PROD_W'(mag_reg) * PROD_W'(RECIP);
            end
            ST_FIN: begin
                res_value_next  = neg_reg ? (~quot + SAMPLE_W'(1)) : quot;
                res_status_next = STAT_OK;
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_ptr_reg] <= s_tdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            empty_reg   <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            empty_reg   <= empty_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        walk_ptr_reg   <= walk_ptr_next;
        cnt_reg        <= cnt_next;
        acc_reg        <= acc_next;
        mag_reg        <= mag_next;
        prod_reg       <= prod_next;
        neg_reg        <= neg_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        if (out_load) begin
            m_value_reg  <= res_value_reg;
            m_status_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_status_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        empty_reg == (wr_ptr_reg == rd_ptr_reg))
        else $error("Empty flag disagrees with the pointers.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != STAT_OK) |-> (m_tdata == '0))
        else $error("Error status returned with a nonzero value.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_tuser == FUNC_PUSH) |=> !empty_reg)
        else $error("Buffer still empty after a push.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SUM) |-> (cnt_reg <= WIN_W'(WINDOW - 1)))
        else $error("Window walk ran past the window length.");

endmodule
